/* rtl/rqf_pkg.sv */
// ----------------------------------------------------------------------------
// Record queue package
// Widths, codes and shared types for the record queue with match-delete.
// ----------------------------------------------------------------------------
package rqf_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int ACT_W   = 3;
    localparam int ID_W    = 27;
    localparam int GRADE_W = 10;
    localparam int KEY_W   = 4;
    localparam int OCC_W   = 7;

    // Match target is key times the grade scale
    localparam int GRADE_SCALE = 100;
    localparam int TGT_W       = KEY_W + 7;

    // Average datapath: the mean of GRADE_W-bit grades fits in GRADE_W bits
    localparam int SUM_W   = GRADE_W + CNT_W;
    localparam int QUO_W   = GRADE_W;
    localparam int QSTEP_W = $clog2(QUO_W);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [ACT_W-1:0] {
        ACT_ENQ  = 3'd0,
        ACT_DEQ  = 3'd1,
        ACT_PEEK = 3'd2,
        ACT_REM  = 3'd3,
        ACT_AVG  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    record_id;
        logic [GRADE_W-1:0] record_grade;
        logic [KEY_W-1:0]   match_key;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    head_id;
        logic [GRADE_W-1:0] head_grade;
        logic [GRADE_W-1:0] mean_grade;
        logic [OCC_W-1:0]   occupancy;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
    } t_rec;

    // Per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_WALK
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_cnt     pos;
        logic     keep;
        t_rec     rec;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

/* rtl/rqf_cell.sv */
// ----------------------------------------------------------------------------
// Record queue cell
// Holds one record slot; loads, shifts toward the head or recirculates.
// ----------------------------------------------------------------------------
module rqf_cell (
    input  logic              i_clk,
    input  rqf_pkg::t_idx     i_index,
    input  rqf_pkg::t_cell_ctl i_ctl,
    input  rqf_pkg::t_rec     i_next,
    output rqf_pkg::t_rec     o_rec
);

    rqf_pkg::t_rec r_rec;
    rqf_pkg::t_rec n_rec;
    rqf_pkg::t_cnt w_slot;

    assign w_slot = rqf_pkg::CNT_W'(i_index);

    // Select this slot's next record
    always_comb begin
        n_rec = r_rec;
        case (i_ctl.op)
            rqf_pkg::CELL_LOAD: begin
                if (w_slot == i_ctl.pos) begin
                    n_rec = i_ctl.rec;
                end
            end
            rqf_pkg::CELL_SHIFT: begin
                n_rec = i_next;
            end
            rqf_pkg::CELL_WALK: begin
                // advance toward the head; the tail slot takes back a kept record
                if (w_slot < i_ctl.pos) begin
                    n_rec = i_next;
                end else if (w_slot == i_ctl.pos && i_ctl.keep) begin
                    n_rec = i_ctl.rec;
                end
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

/* rtl/rqf_div.sv */
// ----------------------------------------------------------------------------
// Record queue divider
// Restoring divider, one quotient bit per cycle, for the grade average.
// ----------------------------------------------------------------------------
module rqf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rqf_pkg::SUM_W-1:0]   i_dividend,
    input  rqf_pkg::t_cnt               i_divisor,
    output logic                        o_done,
    output logic [rqf_pkg::QUO_W-1:0]   o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [rqf_pkg::QSTEP_W-1:0]    r_step;
    logic [rqf_pkg::SUM_W-1:0]      r_rem;
    logic [rqf_pkg::SUM_W-1:0]      r_den;
    logic [rqf_pkg::QUO_W-1:0]      r_quo;
    logic                           w_fit;

    assign w_fit = (r_rem >= r_den);

    // Control: run QUO_W steps after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= rqf_pkg::QSTEP_W'(rqf_pkg::QUO_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Datapath: subtract the shifted divisor where it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= rqf_pkg::SUM_W'({i_divisor, {(rqf_pkg::QUO_W - 1){1'b0}}});
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den;
            end
            r_den <= r_den >> 1;
            r_quo <= {r_quo[rqf_pkg::QUO_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/record_queue_with_filter_core.sv */
// ----------------------------------------------------------------------------
// Record queue with match-delete
// Bounded FIFO of {id, grade} records held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready / i_in_req) carries one action:
//   enqueue, dequeue, peek, remove records of a matching grade, or average.
//   Response channel (o_out_valid / i_out_ready / o_out_rsp) returns exactly
//   one response per request, in order, with the occupancy after the action.
//   The head record always sits in cell 0; dequeue shifts the row by one.
//   Enqueue, dequeue, peek, unused codes and any action on an empty queue
//   go straight from accept to the finish state. Remove-matching walks the
//   row once, one record per cycle. Average walks the same way and then
//   runs a bit-serial divider. One request is in flight at a time, so on a
//   full queue the walk over the cell row dominates an average.
//   The response register frees the core: a new request is accepted while
//   the previous response still waits. A stalled receiver holds the next
//   response in the core until the register empties.
//   Reset (synchronous, active low) empties the queue; cell contents are
//   left as they are and never read before being written.
// ----------------------------------------------------------------------------
module record_queue_with_filter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rqf_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rqf_pkg::t_rsp o_out_rsp
);

    rqf_pkg::t_state                r_state;
    rqf_pkg::t_state                n_state;
    rqf_pkg::t_cnt                  r_count;
    rqf_pkg::t_cnt                  n_count;
    rqf_pkg::t_cnt                  r_steps;
    rqf_pkg::t_cnt                  n_steps;
    logic [rqf_pkg::SUM_W-1:0]      r_sum;
    logic [rqf_pkg::SUM_W-1:0]      n_sum;
    logic [rqf_pkg::TGT_W-1:0]      r_target;
    logic [rqf_pkg::TGT_W-1:0]      n_target;
    logic                           r_is_avg;
    logic                           n_is_avg;
    rqf_pkg::t_rsp                  r_res;
    rqf_pkg::t_rsp                  n_res;
    logic                           r_out_valid;
    rqf_pkg::t_rsp                  r_out;

    logic                           w_accept;
    logic                           w_empty;
    logic                           w_full;
    logic                           w_walk_op;
    logic                           w_last_step;
    logic                           w_keep;
    logic                           w_out_free;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [rqf_pkg::QUO_W-1:0]      w_quotient;
    logic [rqf_pkg::OCC_W+rqf_pkg::CNT_W-1:0] w_occ_wide;
    rqf_pkg::t_cell_ctl             w_ctl;
    rqf_pkg::t_rec                  w_rec [rqf_pkg::QUEUE_DEPTH];

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count >= rqf_pkg::CNT_W'(rqf_pkg::QUEUE_DEPTH));
    assign w_walk_op   = (i_in_req.action == rqf_pkg::ACT_REM) ||
                         (i_in_req.action == rqf_pkg::ACT_AVG);
    assign w_last_step = (r_steps == rqf_pkg::CNT_W'(1));
    assign w_keep      = r_is_avg ||
                         (rqf_pkg::TGT_W'(w_rec[0].grade) != r_target);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_occ_wide  = {{rqf_pkg::OCC_W{1'b0}}, r_count};

    // Cell row: each cell takes its right neighbor's record on a shift
    for (genvar g = 0; g < rqf_pkg::QUEUE_DEPTH; g++) begin : g_cell
        rqf_pkg::t_rec w_next;
        if (g == rqf_pkg::QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_rec[g+1];
        end
        rqf_cell u_cell (
            .i_clk   (i_clk),
            .i_index (rqf_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_next  (w_next),
            .o_rec   (w_rec[g])
        );
    end

    rqf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rqf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_walk_op && !w_empty) ? rqf_pkg::S_WALK
                                                      : rqf_pkg::S_FINISH;
                end
            end
            rqf_pkg::S_WALK: begin
                if (w_last_step) begin
                    n_state = r_is_avg ? rqf_pkg::S_DIV : rqf_pkg::S_FINISH;
                end
            end
            rqf_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = rqf_pkg::S_FINISH;
                end
            end
            rqf_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = rqf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rqf_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs: handshake, cell command, divider start
    always_comb begin
        o_in_ready   = 1'b0;
        w_div_start  = 1'b0;
        w_ctl.op     = rqf_pkg::CELL_HOLD;
        w_ctl.pos    = r_count;
        w_ctl.keep   = 1'b0;
        w_ctl.rec.id    = i_in_req.record_id;
        w_ctl.rec.grade = i_in_req.record_grade;
        case (r_state)
            rqf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_req.action == rqf_pkg::ACT_ENQ && !w_full) begin
                    w_ctl.op = rqf_pkg::CELL_LOAD;
                end else if (i_in_valid && i_in_req.action == rqf_pkg::ACT_DEQ &&
                             !w_empty) begin
                    w_ctl.op = rqf_pkg::CELL_SHIFT;
                end
            end
            rqf_pkg::S_WALK: begin
                // pop the head and append it at the live tail if kept
                w_ctl.op    = rqf_pkg::CELL_WALK;
                w_ctl.pos   = r_count - 1'b1;
                w_ctl.keep  = w_keep;
                w_ctl.rec   = w_rec[0];
                w_div_start = w_last_step && r_is_avg;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_count  = r_count;
        n_steps  = r_steps;
        n_sum    = r_sum;
        n_target = r_target;
        n_is_avg = r_is_avg;
        n_res    = r_res;
        if (w_accept) begin
            n_res            = '0;
            n_res.status     = rqf_pkg::ST_OK;
            n_steps          = r_count;
            n_sum            = '0;
            n_target         = rqf_pkg::TGT_W'(i_in_req.match_key) *
                               rqf_pkg::TGT_W'(rqf_pkg::GRADE_SCALE);
            n_is_avg         = (i_in_req.action == rqf_pkg::ACT_AVG);
            case (i_in_req.action)
                rqf_pkg::ACT_ENQ: begin
                    if (w_full) begin
                        n_res.status = rqf_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                rqf_pkg::ACT_DEQ: begin
                    if (w_empty) begin
                        n_res.status = rqf_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                rqf_pkg::ACT_PEEK: begin
                    if (w_empty) begin
                        n_res.status = rqf_pkg::ST_EMPTY;
                    end else begin
                        n_res.head_id    = w_rec[0].id;
                        n_res.head_grade = w_rec[0].grade;
                    end
                end
                rqf_pkg::ACT_REM, rqf_pkg::ACT_AVG: begin
                    if (w_empty) begin
                        n_res.status = rqf_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    n_res.status = rqf_pkg::ST_OK;
                end
            endcase
        end else if (r_state == rqf_pkg::S_WALK) begin
            // drop a matching record, accumulate the grade for the average
            n_steps = r_steps - 1'b1;
            n_sum   = r_sum + rqf_pkg::SUM_W'(w_rec[0].grade);
            if (!w_keep) begin
                n_count = r_count - 1'b1;
            end
        end else if (r_state == rqf_pkg::S_DIV && w_div_done) begin
            n_res.mean_grade = w_quotient;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rqf_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == rqf_pkg::S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_steps  <= n_steps;
        r_sum    <= n_sum;
        r_target <= n_target;
        r_is_avg <= n_is_avg;
        r_res    <= n_res;
        if (r_state == rqf_pkg::S_FINISH && w_out_free) begin
            r_out           <= r_res;
            r_out.occupancy <= w_occ_wide[rqf_pkg::OCC_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rqf_pkg::CNT_W'(rqf_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_walk_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rqf_pkg::S_WALK) |=> (r_count <= $past(r_count)))
        else $error("count grew during a walk");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_req.action == rqf_pkg::ACT_ENQ && !w_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not advance the count");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == rqf_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_avg_walk_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rqf_pkg::S_WALK && r_is_avg) |=> (r_count == $past(r_count)))
        else $error("average walk changed the count");

endmodule

/* bench/record_queue_with_filter_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Record queue with match-delete testbench
// Drives enqueue, dequeue, peek, remove-matching and average requests through
// the valid/ready request channel, tracks the expected queue contents in a
// scoreboard, and checks every response field in order. Covers empty, full,
// out-of-range grades and ids, keys that cannot match, unused action codes,
// random stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module record_queue_with_filter_core_tb;

    localparam int          HALF_PERIOD  = 4;
    localparam int          ITEM_TARGET  = 1550;
    localparam int          QUIET_TAIL   = 200;
    localparam int          LONG_HOLD    = 400;
    localparam int          PRESSURE_LEN = 90;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          SETTLE_TIME  = 100;
    localparam int          WATCHDOG_NS  = 8000000;
    localparam logic [rqf_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [rqf_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_SPREAD } t_mix;

    // Track queue contents and the responses they imply
    class record_queue_tracker;
        rqf_pkg::t_rec slots [rqf_pkg::QUEUE_DEPTH];
        int unsigned   front_slot;
        int unsigned   held;
        rqf_pkg::t_rsp pending_responses[$];
        int unsigned   fail_count;

        function new();
            front_slot = 0;
            held       = 0;
            fail_count = 0;
        endfunction

        // Apply one accepted request and queue its expected response
        function void note_request(rqf_pkg::t_req req);
            rqf_pkg::t_rsp   rsp;
            rqf_pkg::t_rec   entry;
            int unsigned     target;
            int unsigned     kept;
            longint unsigned grade_sum;
            rsp        = '0;
            rsp.status = rqf_pkg::ST_OK;
            case (req.action)
                rqf_pkg::ACT_ENQ: begin
                    if (held >= rqf_pkg::QUEUE_DEPTH) begin
                        rsp.status = rqf_pkg::ST_FULL;
                    end else begin
                        entry.id    = req.record_id;
                        entry.grade = req.record_grade;
                        slots[(front_slot + held) % rqf_pkg::QUEUE_DEPTH] = entry;
                        held++;
                    end
                end
                rqf_pkg::ACT_DEQ: begin
                    if (held == 0) begin
                        rsp.status = rqf_pkg::ST_EMPTY;
                    end else begin
                        front_slot = (front_slot + 1) % rqf_pkg::QUEUE_DEPTH;
                        held--;
                    end
                end
                rqf_pkg::ACT_PEEK: begin
                    if (held == 0) begin
                        rsp.status = rqf_pkg::ST_EMPTY;
                    end else begin
                        rsp.head_id    = slots[front_slot].id;
                        rsp.head_grade = slots[front_slot].grade;
                    end
                end
                rqf_pkg::ACT_REM: begin
                    if (held == 0) begin
                        rsp.status = rqf_pkg::ST_EMPTY;
                    end else begin
                        // compact survivors toward the head, keeping order
                        target = req.match_key * rqf_pkg::GRADE_SCALE;
                        kept   = 0;
                        for (int i = 0; i < held; i++) begin
                            entry = slots[(front_slot + i) % rqf_pkg::QUEUE_DEPTH];
                            if (entry.grade != target) begin
                                slots[(front_slot + kept) % rqf_pkg::QUEUE_DEPTH] = entry;
                                kept++;
                            end
                        end
                        held = kept;
                    end
                end
                rqf_pkg::ACT_AVG: begin
                    if (held == 0) begin
                        rsp.status = rqf_pkg::ST_EMPTY;
                    end else begin
                        grade_sum = 0;
                        for (int i = 0; i < held; i++) begin
                            grade_sum +=
                                slots[(front_slot + i) % rqf_pkg::QUEUE_DEPTH].grade;
                        end
                        rsp.mean_grade = rqf_pkg::GRADE_W'(grade_sum / held);
                    end
                end
                default: begin
                end
            endcase
            rsp.occupancy = rqf_pkg::OCC_W'(held);
            pending_responses.push_back(rsp);
        endfunction

        // Compare one accepted response with the oldest expectation
        function void check_response(rqf_pkg::t_rsp got);
            rqf_pkg::t_rsp want;
            if (pending_responses.size() == 0) begin
                $error("response with no request outstanding: %h", got);
                fail_count++;
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.head_id !== want.head_id) begin
                $error("head_id: expected %0d, actual %0d", want.head_id, got.head_id);
                fail_count++;
            end
            if (got.head_grade !== want.head_grade) begin
                $error("head_grade: expected %0d, actual %0d",
                       want.head_grade, got.head_grade);
                fail_count++;
            end
            if (got.mean_grade !== want.mean_grade) begin
                $error("mean_grade: expected %0d, actual %0d",
                       want.mean_grade, got.mean_grade);
                fail_count++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d",
                       want.occupancy, got.occupancy);
                fail_count++;
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    rqf_pkg::t_req  i_in_req    = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    rqf_pkg::t_rsp  o_out_rsp;

    record_queue_tracker sb;
    int unsigned         sent_count   = 0;
    bit                  send_idle_on = 1'b1;
    bit                  recv_idle_on = 1'b1;
    bit                  hold_request = 1'b0;

    record_queue_with_filter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    // Free-running clock
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Sample both handshakes mid-cycle, where nothing is changing
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_response(o_out_rsp);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in_req);
            end
        end
    end

    // Drive response ready: long hold on request, else random stall bursts
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic rqf_pkg::t_req make_req(logic [rqf_pkg::ACT_W-1:0] act,
                                               logic [rqf_pkg::ID_W-1:0] id,
                                               logic [rqf_pkg::GRADE_W-1:0] grade,
                                               logic [rqf_pkg::KEY_W-1:0] key);
        rqf_pkg::t_req req;
        req.action       = act;
        req.record_id    = id;
        req.record_grade = grade;
        req.match_key    = key;
        return req;
    endfunction

    // Request whose id and grade are don't-care noise
    function automatic rqf_pkg::t_req bare_req(logic [rqf_pkg::ACT_W-1:0] act,
                                               logic [rqf_pkg::KEY_W-1:0] key);
        return make_req(act, rqf_pkg::ID_W'($urandom), rqf_pkg::GRADE_W'($urandom), key);
    endfunction

    // Build a random request biased by the current traffic mix
    function automatic rqf_pkg::t_req random_request(t_mix mix);
        rqf_pkg::t_req req;
        int unsigned   roll;
        int unsigned   enq_share;
        int unsigned   deq_share;
        req.record_id = rqf_pkg::ID_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            req.record_grade =
                rqf_pkg::GRADE_W'(rqf_pkg::GRADE_SCALE * $urandom_range(0, 10));
        end else if (roll < 90) begin
            req.record_grade = rqf_pkg::GRADE_W'($urandom_range(0, 1000));
        end else begin
            req.record_grade = rqf_pkg::GRADE_W'($urandom_range(1001, 1023));
        end
        req.match_key = ($urandom_range(0, 99) < 80)
                        ? rqf_pkg::KEY_W'($urandom_range(0, 10))
                        : rqf_pkg::KEY_W'($urandom_range(11, 15));
        case (mix)
            MIX_FILL: begin
                enq_share = 70;
                deq_share = 8;
            end
            MIX_DRAIN: begin
                enq_share = 15;
                deq_share = 50;
            end
            default: begin
                enq_share = 35;
                deq_share = 25;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            req.action = rqf_pkg::ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end else if (roll < 3 + enq_share) begin
            req.action = rqf_pkg::ACT_ENQ;
        end else if (roll < 3 + enq_share + deq_share) begin
            req.action = rqf_pkg::ACT_DEQ;
        end else begin
            case ($urandom_range(0, 2))
                0:       req.action = rqf_pkg::ACT_PEEK;
                1:       req.action = rqf_pkg::ACT_REM;
                default: req.action = rqf_pkg::ACT_AVG;
            endcase
        end
        return req;
    endfunction

    // Offer one request, hold it until accepted, then maybe idle a burst
    task automatic issue_request(input rqf_pkg::t_req req);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        sent_count++;
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Main stimulus
    initial begin
        t_mix        mix;
        int unsigned phase_len;
        int unsigned waited;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each action but enqueue on an empty queue, unused codes included
        issue_request(bare_req(rqf_pkg::ACT_PEEK, 4'd3));
        issue_request(bare_req(rqf_pkg::ACT_DEQ, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_REM, 4'd10));
        issue_request(bare_req(rqf_pkg::ACT_AVG, 4'd0));
        issue_request(bare_req(ACT_SPARE_LO, 4'd5));
        issue_request(bare_req(ACT_SPARE_LO + 3'd1, 4'd9));
        issue_request(bare_req(ACT_SPARE_HI, 4'd15));

        // Extreme ids and grades, including out-of-range values
        issue_request(make_req(rqf_pkg::ACT_ENQ, '0, '0, '0));
        issue_request(make_req(rqf_pkg::ACT_ENQ, '1, '1, '1));
        issue_request(make_req(rqf_pkg::ACT_ENQ, rqf_pkg::ID_W'(99999999),
                               rqf_pkg::GRADE_W'(1000), 4'd0));
        issue_request(make_req(rqf_pkg::ACT_ENQ, rqf_pkg::ID_W'($urandom),
                               rqf_pkg::GRADE_W'(500), 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_PEEK, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_AVG, 4'd0));

        // Key that cannot match, then matches at the head and in the middle
        issue_request(bare_req(rqf_pkg::ACT_REM, 4'd15));
        issue_request(bare_req(rqf_pkg::ACT_REM, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_PEEK, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_REM, 4'd10));
        issue_request(bare_req(rqf_pkg::ACT_AVG, 4'd0));
        issue_request(bare_req(ACT_SPARE_HI, 4'd0));

        // Drain to empty and past it
        issue_request(bare_req(rqf_pkg::ACT_DEQ, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_PEEK, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_DEQ, 4'd0));
        issue_request(bare_req(rqf_pkg::ACT_DEQ, 4'd0));

        // Hold off the receiver and stream fill-biased requests so the input stalls
        send_idle_on = 1'b0;
        hold_request = 1'b1;
        repeat (PRESSURE_LEN) issue_request(random_request(MIX_FILL));

        // Random phases of filling, draining and spread traffic
        while (sent_count < ITEM_TARGET) begin
            mix          = t_mix'($urandom_range(0, 2));
            phase_len    = $urandom_range(20, 120);
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len) begin
                if (sent_count >= ITEM_TARGET) begin
                    break;
                end
                if (sent_count >= ITEM_TARGET - QUIET_TAIL) begin
                    send_idle_on = 1'b0;
                    recv_idle_on = 1'b0;
                end
                issue_request(random_request(mix));
            end
        end
        i_in_valid <= 1'b0;

        // Wait for outstanding responses, then let the block settle
        waited = 0;
        while (sb.pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_TIME) @(posedge i_clk);

        if (sb.pending_responses.size() != 0) begin
            $error("%0d responses never arrived", sb.pending_responses.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
